/* src/rfpf_pkg.sv */
// Shared types, constants and helper functions for the ring FIFO.
package rfpf_pkg;

	localparam int DEPTH_DEF     = 16;
	localparam int ELEM_BITS_DEF = 32;

	localparam int CMD_W   = 2;
	localparam int DATA_W  = 32;
	localparam int OFF_W   = 4;
	localparam int CAP_W   = 5;
	localparam int COUNT_W = 5;
	localparam int STAT_W  = 2;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH  = 2'd0,
		CMD_POP   = 2'd1,
		CMD_PEEK  = 2'd2,
		CMD_FLUSH = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NO_ENTRY = 2'd2
	} status_t;

	// Result fields that leave the control logic for the result register
	typedef struct packed {
		status_t              status;
		logic [COUNT_W-1:0]   count;
		logic                 full;
		logic                 empty;
		logic                 rd;
	} res_t;

	// Largest power of two not above v; elaboration only
	function automatic int floor_pow2(input int v);
		int p;
		p = 1;
		while (p * 2 <= v)
			p = p * 2;
		return p;
	endfunction

	// Clamp the requested capacity into 1..depth, then round down to a power of two
	function automatic logic [CAP_W-1:0] eff_cap(input logic [CAP_W-1:0] cap, input int depth);
		logic [CAP_W-1:0] lim;
		logic [CAP_W-1:0] eff;
		lim = cap;
		eff = '0;
		if (int'(cap) > depth)
			lim = CAP_W'(depth);
		if (lim == '0)
			lim = CAP_W'(1);
		for (int i = 0; i < CAP_W; i++) begin
			if (lim[i])
				eff = CAP_W'(1) << i;
		end
		return eff;
	endfunction

endpackage

/* src/rfpf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rfpf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* src/rfpf_ctrl.sv */
// Pointer registers, capacity register and per-command decision logic.
module rfpf_ctrl #(
	parameter int DEPTH = rfpf_pkg::DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         acc,
	input  logic [rfpf_pkg::CMD_W-1:0]   cmd,
	input  logic [rfpf_pkg::OFF_W-1:0]   offset,
	input  logic                         cfg_we,
	input  logic [rfpf_pkg::CAP_W-1:0]   capacity,
	output logic                         ram_we,
	output logic [$clog2(DEPTH)-1:0]     ram_waddr,
	output logic                         ram_re,
	output logic [$clog2(DEPTH)-1:0]     ram_raddr,
	output rfpf_pkg::res_t               res_n
);
	import rfpf_pkg::*;

	localparam int AW     = $clog2(DEPTH);
	localparam int PDEPTH = floor_pow2(DEPTH);
	localparam int PW     = $clog2(PDEPTH) + 1;
	localparam int CW     = (PW > CAP_W) ? PW : CAP_W;
	localparam logic [CAP_W-1:0] CAP_EFF_RST = eff_cap(CAP_RESET, DEPTH);

	logic [PW-1:0]    wp_q, rp_q;
	logic [CAP_W-1:0] cap_eff_q;

	cmd_t          cmd_c;
	logic [PW-1:0] wp_n, rp_n;
	logic [PW-1:0] cnt, cnt_n;
	logic [PW-1:0] imask;
	logic [PW-1:0] peek_ptr;
	logic [CW-1:0] cnt_x, cap_x, off_x;
	status_t       st;
	logic          wr, rd;

	assign cmd_c    = cmd_t'(cmd);
	assign cnt      = wp_q - rp_q;
	assign imask    = PW'(cap_eff_q - CAP_W'(1));
	assign peek_ptr = rp_q + PW'(offset);
	assign cnt_x    = CW'(cnt);
	assign cap_x    = CW'(cap_eff_q);
	assign off_x    = CW'(offset);

	always_comb begin
		wp_n      = wp_q;
		rp_n      = rp_q;
		wr        = 1'b0;
		rd        = 1'b0;
		st        = ST_OK;
		ram_raddr = AW'(rp_q & imask);
		unique case (cmd_c)
			CMD_PUSH: begin
				if (cnt_x >= cap_x) begin
					st = ST_FULL;
				end else begin
					wr   = 1'b1;
					wp_n = wp_q + PW'(1);
				end
			end
			CMD_POP: begin
				if (cnt == '0) begin
					st = ST_NO_ENTRY;
				end else begin
					rd   = 1'b1;
					rp_n = rp_q + PW'(1);
				end
			end
			CMD_PEEK: begin
				if (cnt_x <= off_x) begin
					st = ST_NO_ENTRY;
				end else begin
					rd        = 1'b1;
					ram_raddr = AW'(peek_ptr & imask);
				end
			end
			CMD_FLUSH: begin
				rp_n = wp_q;
			end
			default: begin
				st = ST_OK;
			end
		endcase
	end

	assign cnt_n     = wp_n - rp_n;
	assign ram_we    = acc && wr;
	assign ram_re    = acc && rd;
	assign ram_waddr = AW'(wp_q & imask);

	always_comb begin
		res_n.status = st;
		res_n.count  = COUNT_W'(cnt_n);
		res_n.full   = (CW'(cnt_n) == cap_x);
		res_n.empty  = (cnt_n == '0);
		res_n.rd     = rd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			rp_q      <= '0;
			cap_eff_q <= CAP_EFF_RST;
		end else if (cfg_we) begin
			// new capacity empties the queue; stored data stays
			wp_q      <= '0;
			rp_q      <= '0;
			cap_eff_q <= eff_cap(capacity, DEPTH);
		end else if (acc) begin
			wp_q <= wp_n;
			rp_q <= rp_n;
		end
	end

`ifndef SYNTH
	a_cnt_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_x <= cap_x)
		else $error("stored count exceeds effective capacity");

	a_flush_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && cmd_c == CMD_FLUSH) |=> (wp_q == rp_q))
		else $error("flush did not empty the queue");
`endif

endmodule

/* src/ring_fifo_with_peek_and_flush.sv */
// Ring FIFO with peek and flush: top level with storage and result register.
//
// Usage:
//   Request channel (req_valid / req_stall) carries one command per request:
//   push push_data, pop the oldest element, peek at offset from the oldest,
//   or flush. Result channel (res_valid / res_stall) returns exactly one
//   result per request: status, data_out, count, full_res and empty_res.
//   The result is valid in the cycle after the request is taken; one request
//   is taken per cycle while req_stall is low, set by the single-pass
//   pointer logic and the one read port of the storage RAM.
//   When a result is waiting and the receiver holds res_stall, req_stall is
//   raised and the result and its read data hold until taken.
//   The user writes the capacity register with cfg_we only while no request
//   is in flight, unchecked by the block; a write sets the effective capacity
//   (clamped to DEPTH, rounded down to a power of two) and empties the queue.
//   Reset clears both pointers, sets the capacity to 16 and drops res_valid.
//   Storage contents are not cleared; only written slots are ever read.
module ring_fifo_with_peek_and_flush #(
	parameter int DEPTH     = rfpf_pkg::DEPTH_DEF,
	parameter int ELEM_BITS = rfpf_pkg::ELEM_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [rfpf_pkg::CMD_W-1:0]    cmd,
	input  logic [rfpf_pkg::DATA_W-1:0]   push_data,
	input  logic [rfpf_pkg::OFF_W-1:0]    offset,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [rfpf_pkg::STAT_W-1:0]   status,
	output logic [rfpf_pkg::DATA_W-1:0]   data_out,
	output logic [rfpf_pkg::COUNT_W-1:0]  count,
	output logic                          full_res,
	output logic                          empty_res,
	input  logic                          cfg_we,
	input  logic [rfpf_pkg::CAP_W-1:0]    capacity
);
	import rfpf_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int XW = (ELEM_BITS > DATA_W) ? ELEM_BITS : DATA_W;

	logic                 acc;
	logic                 ram_we, ram_re;
	logic [AW-1:0]        ram_waddr, ram_raddr;
	logic [ELEM_BITS-1:0] ram_rdata;
	logic [XW-1:0]        rd_ext;
	res_t                 res_n;
	res_t                 res_s1;
	logic                 vld_s1;

	assign req_stall = vld_s1 && res_stall;
	assign acc       = req_valid && !req_stall;

	rfpf_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.cmd       (cmd),
		.offset    (offset),
		.cfg_we    (cfg_we),
		.capacity  (capacity),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.res_n     (res_n)
	);

	rfpf_ram #(
		.WIDTH (ELEM_BITS),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ELEM_BITS'(push_data)),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (acc) begin
			vld_s1 <= 1'b1;
		end else if (!res_stall) begin
			vld_s1 <= 1'b0;
		end
	end

	// hold the result while the receiver stalls
	always_ff @(posedge clk) begin
		if (acc)
			res_s1 <= res_n;
	end

	assign rd_ext    = XW'(ram_rdata);
	assign res_valid = vld_s1;
	assign status    = res_s1.status;
	assign data_out  = res_s1.rd ? rd_ext[DATA_W-1:0] : '0;
	assign count     = res_s1.count;
	assign full_res  = res_s1.full;
	assign empty_res = res_s1.empty;

`ifndef SYNTH
	a_acc_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> res_valid)
		else $error("accepted request produced no result");

	a_full_status_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_s1.status == ST_FULL) |-> (full_res && !res_s1.rd))
		else $error("full status without full flag or with read data");

	a_stall_only_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (vld_s1 && res_stall))
		else $error("request stalled without a held result");
`endif

endmodule

/* verif/ring_fifo_with_peek_and_flush_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the ring FIFO: command stimulus, result prediction and checking.
module ring_fifo_with_peek_and_flush_tb;
	import rfpf_pkg::*;

	localparam int QUIET_LIMIT = 2000;

	// Tracks the queue contents and pointers, and holds the answers still owed by the block
	class fifo_scoreboard;
		typedef struct {
			status_t     status;
			logic [31:0] word;
			logic [4:0]  fill;
			logic        full;
			logic        empty;
		} answer_t;

		logic [31:0] slots [16];
		logic [4:0]  wr_ptr;
		logic [4:0]  rd_ptr;
		logic [4:0]  requested;
		answer_t     answers [$];
		int          errors;

		function new();
			foreach (slots[i])
				slots[i] = '0;
			wr_ptr = '0;
			rd_ptr = '0;
			requested = CAP_RESET;
			errors = 0;
		endfunction

		// Clamp into 1..16, then take the largest power of two not above it
		function int usable_slots();
			int lim;
			lim = int'(requested);
			if (lim > 16)
				lim = 16;
			if (lim == 0)
				lim = 1;
			for (int p = 16; p > 1; p = p / 2)
				if (lim >= p)
					return p;
			return 1;
		endfunction

		function void set_capacity(logic [4:0] value);
			requested = value;
			wr_ptr = '0;
			rd_ptr = '0;
		endfunction

		function int pending();
			return answers.size();
		endfunction

		function void note_request(cmd_t op, logic [31:0] word, logic [3:0] pos);
			answer_t    a;
			int         lim;
			logic [3:0] imask;
			logic [4:0] fill;
			lim = usable_slots();
			imask = 4'(lim - 1);
			fill = wr_ptr - rd_ptr;
			a.status = ST_OK;
			a.word = '0;
			case (op)
				CMD_PUSH: begin
					if (fill >= lim) begin
						a.status = ST_FULL;
					end else begin
						slots[wr_ptr[3:0] & imask] = word;
						wr_ptr = wr_ptr + 5'd1;
					end
				end
				CMD_POP: begin
					if (fill == 0) begin
						a.status = ST_NO_ENTRY;
					end else begin
						a.word = slots[rd_ptr[3:0] & imask];
						rd_ptr = rd_ptr + 5'd1;
					end
				end
				CMD_PEEK: begin
					if (fill <= pos)
						a.status = ST_NO_ENTRY;
					else
						a.word = slots[4'(rd_ptr[3:0] + pos) & imask];
				end
				default: begin
					rd_ptr = wr_ptr;
				end
			endcase
			fill = wr_ptr - rd_ptr;
			a.fill = fill;
			a.full = (fill == lim);
			a.empty = (fill == 0);
			answers.push_back(a);
		endfunction

		task report_mismatch(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(logic [1:0] st, logic [31:0] word, logic [4:0] fill,
				logic full, logic empty);
			answer_t a;
			if (answers.size() == 0) begin
				report_mismatch("result with no request outstanding");
			end else begin
				a = answers.pop_front();
				if (st !== a.status)
					report_mismatch($sformatf("status %0d, want %0d", st, a.status));
				if (word !== a.word)
					report_mismatch($sformatf("data_out %h, want %h", word, a.word));
				if (fill !== a.fill)
					report_mismatch($sformatf("count %0d, want %0d", fill, a.fill));
				if (full !== a.full)
					report_mismatch($sformatf("full_res %b, want %b", full, a.full));
				if (empty !== a.empty)
					report_mismatch($sformatf("empty_res %b, want %b", empty, a.empty));
			end
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	logic [CMD_W-1:0]     cmd = '0;
	logic [DATA_W-1:0]    push_data = '0;
	logic [OFF_W-1:0]     offset = '0;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	logic [STAT_W-1:0]    status;
	logic [DATA_W-1:0]    data_out;
	logic [COUNT_W-1:0]   count;
	logic                 full_res;
	logic                 empty_res;
	logic                 cfg_we = 1'b0;
	logic [CAP_W-1:0]     capacity = '0;

	fifo_scoreboard sb;
	int idle_pct = 20;
	bit tail_quiet = 1'b0;
	int stall_left = 0;
	int quiet_cycles = 0;

	ring_fifo_with_peek_and_flush dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.cmd       (cmd),
		.push_data (push_data),
		.offset    (offset),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.status    (status),
		.data_out  (data_out),
		.count     (count),
		.full_res  (full_res),
		.empty_res (empty_res),
		.cfg_we    (cfg_we),
		.capacity  (capacity)
	);

	always #10 clk = ~clk;

	// Result-side backpressure in short random bursts
	always @(posedge clk) begin
		if (tail_quiet) begin
			res_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			res_stall <= 1'b1;
		end else if ($urandom_range(0, 99) < idle_pct) begin
			stall_left = $urandom_range(0, 4);
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	// Sample both channels and the register port; watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				sb.set_capacity(capacity);
			if (res_valid && !res_stall)
				sb.check_result(status, data_out, count, full_res, empty_res);
			if (req_valid && !req_stall)
				sb.note_request(cmd_t'(cmd), push_data, offset);
			if ((req_valid && !req_stall) || (res_valid && !res_stall) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic send_request(input cmd_t op, input logic [31:0] word, input logic [3:0] pos);
		int gap;
		gap = 0;
		if (!tail_quiet && $urandom_range(0, 99) < idle_pct)
			gap = $urandom_range(1, 5);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		cmd <= op;
		push_data <= word;
		offset <= pos;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	// Drain all outstanding requests, then write the capacity register
	task automatic write_capacity(input logic [4:0] value);
		req_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
		cfg_we <= 1'b1;
		capacity <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_random(input int items);
		int          push_pct;
		int          r;
		cmd_t        op;
		logic [31:0] word;
		logic [3:0]  pos;
		push_pct = 50;
		for (int n = 0; n < items; n++) begin
			// shift between filling and draining so full and empty both get hit
			if (n % 16 == 0)
				push_pct = $urandom_range(25, 70);
			r = $urandom_range(0, 99);
			if (r < push_pct) begin
				op = CMD_PUSH;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 55)
					op = CMD_POP;
				else if (r < 93)
					op = CMD_PEEK;
				else
					op = CMD_FLUSH;
			end
			case ($urandom_range(0, 9))
				0: word = '0;
				1: word = '1;
				default: word = $urandom();
			endcase
			if ($urandom_range(0, 1) != 0)
				pos = 4'($urandom_range(0, 3));
			else
				pos = 4'($urandom_range(0, 15));
			send_request(op, word, pos);
		end
	endtask

	logic [4:0] plan [9] = '{5'd31, 5'd1, 5'd4, 5'd0, 5'd7, 5'd2, 5'd17, 5'd12, 5'd8};

	initial begin
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue at reset capacity, then push, peek, pop and flush on a short queue
		send_request(CMD_POP, 32'h0, 4'd0);
		send_request(CMD_PEEK, 32'h0, 4'd0);
		send_request(CMD_FLUSH, 32'h0, 4'd0);
		send_request(CMD_PUSH, 32'h0000_0000, 4'd0);
		send_request(CMD_PUSH, 32'hFFFF_FFFF, 4'd15);
		send_request(CMD_PEEK, 32'h0, 4'd1);
		send_request(CMD_PEEK, 32'h0, 4'd15);
		send_request(CMD_POP, 32'h0, 4'd0);
		send_request(CMD_FLUSH, 32'h0, 4'd0);
		send_request(CMD_POP, 32'h0, 4'd0);
		send_request(CMD_PUSH, 32'hA5A5_A5A5, 4'd0);

		// zero capacity acts as one; the write also empties the queue
		write_capacity(5'd0);
		send_request(CMD_POP, 32'h0, 4'd0);
		send_request(CMD_PUSH, 32'h5A5A_5A5A, 4'd0);
		send_request(CMD_PUSH, 32'h1234_5678, 4'd0);
		send_request(CMD_PEEK, 32'h0, 4'd0);
		send_request(CMD_POP, 32'h0, 4'd0);

		// above the storage depth: clamp to sixteen
		write_capacity(5'd31);
		send_request(CMD_PUSH, 32'hDEAD_BEEF, 4'd0);
		send_request(CMD_PEEK, 32'h0, 4'd0);

		foreach (plan[i]) begin
			case ($urandom_range(0, 2))
				0: idle_pct = 0;
				1: idle_pct = 10;
				default: idle_pct = 30;
			endcase
			write_capacity(plan[i]);
			run_random(50);
		end

		write_capacity(5'($urandom_range(0, 31)));
		run_random(30);

		// full-rate tail at the reset capacity
		write_capacity(5'd16);
		tail_quiet = 1'b1;
		run_random(60);

		req_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* files.f */
src/rfpf_pkg.sv
src/rfpf_ram.sv
src/rfpf_ctrl.sv
src/ring_fifo_with_peek_and_flush.sv
verif/ring_fifo_with_peek_and_flush_tb.sv
